FILE: hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, masked while reset is asserted.
`define TDMQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tdmq: assertion failed");

// Check a property on every rising clock edge, reset included.
`define TDMQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tdmq: assertion failed");

`endif

FILE: hdl/tdmq_pkg.sv
`default_nettype none

package tdmq_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned TAG_W = 32;
  localparam int unsigned REC_W = KEY_W + TAG_W;

  // Command codes carried in the slave-side tuser
  localparam logic [1:0] CMD_PUSH_A = 2'd0;
  localparam logic [1:0] CMD_PUSH_B = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;

  // Status codes returned with every result
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the incoming transaction
    logic commit;  // execute the captured command and load the result register
  } tdmq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } tdmq_sts_t;

endpackage

`default_nettype wire

FILE: hdl/two_way_descending_merge_queue.sv
// Each accepted input is captured, then executed, and no new input is accepted before
// it executes; the result is offered from the result register. The queue heads come
// from a registered memory read, and the key compare and pointer update follow it.
// A pending result waiting on m_axis_tready_i lets one more input be accepted; that
// input then waits to execute until the pending result is taken.
// Reset (rst_ni low, asynchronous) empties both runs: pointers, counts and control
// clear at once; the queue memories are not cleared and need no clearing pass.
`default_nettype none

module two_way_descending_merge_queue #(
  parameter int unsigned RUN_DEPTH = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // [31:0] key, [63:32] tag
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] command
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [63:0]      m_axis_tdata_o,   // [31:0] out_key, [63:32] out_tag
  output logic [2:0]       m_axis_tuser_o    // [0] from_run, [2:1] status
);
  import tdmq_pkg::*;

  tdmq_cmd_t        cmd;
  tdmq_sts_t        sts;
  logic [KEY_W-1:0] out_key;
  logic [TAG_W-1:0] out_tag;
  logic             out_from_run;
  logic [1:0]       out_status;

  tdmq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tdmq_dp #(
    .RUN_DEPTH (RUN_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_command_i   (s_axis_tuser_i),
    .in_key_i       (s_axis_tdata_i[KEY_W-1:0]),
    .in_tag_i       (s_axis_tdata_i[REC_W-1:KEY_W]),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_key_o      (out_key),
    .out_tag_o      (out_tag),
    .out_from_run_o (out_from_run),
    .out_status_o   (out_status)
  );

  // Pack the result fields onto the master side
  assign m_axis_tdata_o = {out_tag, out_key};
  assign m_axis_tuser_o = {out_status, out_from_run};

endmodule

`default_nettype wire

FILE: hdl/tdmq_ctrl.sv
`default_nettype none

module tdmq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire tdmq_pkg::tdmq_sts_t sts_i,
  output tdmq_pkg::tdmq_cmd_t     cmd_o
);
  import tdmq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;

  // Accept one transaction in idle, execute it once the result register frees up
  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o.load   = 1'b0;
    cmd_o.commit = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tdmq_dp.sv
`default_nettype none

module tdmq_dp #(
  parameter int unsigned RUN_DEPTH = 512
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire tdmq_pkg::tdmq_cmd_t         cmd_i,
  output tdmq_pkg::tdmq_sts_t              sts_o,
  input  wire logic [1:0]                  in_command_i,
  input  wire logic [tdmq_pkg::KEY_W-1:0]  in_key_i,
  input  wire logic [tdmq_pkg::TAG_W-1:0]  in_tag_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [tdmq_pkg::KEY_W-1:0]       out_key_o,
  output logic [tdmq_pkg::TAG_W-1:0]       out_tag_o,
  output logic                             out_from_run_o,
  output logic [1:0]                       out_status_o
);
  import tdmq_pkg::*;

  localparam int unsigned PTR_W = $clog2(RUN_DEPTH);
  localparam int unsigned CNT_W = $clog2(RUN_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RUN_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RUN_DEPTH);

  // Queue memories, key in the upper half of each record
  logic [REC_W-1:0] mem_a [RUN_DEPTH];
  logic [REC_W-1:0] mem_b [RUN_DEPTH];

  logic [1:0]       command_q;
  logic [KEY_W-1:0] key_q;
  logic [TAG_W-1:0] tag_q;
  logic [REC_W-1:0] head_a_q, head_b_q;

  logic [PTR_W-1:0] rd_a_q, rd_a_d, wr_a_q, wr_a_d;
  logic [PTR_W-1:0] rd_b_q, rd_b_d, wr_b_q, wr_b_d;
  logic [CNT_W-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;

  logic             out_valid_q, out_valid_d;
  logic [KEY_W-1:0] out_key_q, out_key_d;
  logic [TAG_W-1:0] out_tag_q, out_tag_d;
  logic             out_run_q, out_run_d;
  logic [1:0]       out_status_q, out_status_d;

  logic we_a, we_b;
  logic have_a, have_b, take_a;

  // Capture the accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      command_q <= in_command_i;
      key_q     <= in_key_i;
      tag_q     <= in_tag_i;
    end
  end

  // Write pushed records, read both heads every cycle
  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[wr_a_q] <= {key_q, tag_q};
    end
    if (we_b) begin
      mem_b[wr_b_q] <= {key_q, tag_q};
    end
    head_a_q <= mem_a[rd_a_q];
    head_b_q <= mem_b[rd_b_q];
  end

  assign have_a = (cnt_a_q != '0);
  assign have_b = (cnt_b_q != '0);
  // Greater key wins, run A on a tie
  assign take_a = have_a &&
                  (!have_b || (head_a_q[REC_W-1:TAG_W] >= head_b_q[REC_W-1:TAG_W]));

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Execute the captured command
  always_comb begin
    we_a         = 1'b0;
    we_b         = 1'b0;
    rd_a_d       = rd_a_q;
    wr_a_d       = wr_a_q;
    cnt_a_d      = cnt_a_q;
    rd_b_d       = rd_b_q;
    wr_b_d       = wr_b_q;
    cnt_b_d      = cnt_b_q;
    out_key_d    = '0;
    out_tag_d    = '0;
    out_run_d    = 1'b0;
    out_status_d = ST_OK;
    case (command_q)
      CMD_PUSH_A: begin
        if (cnt_a_q == CNT_FULL) begin
          out_status_d = ST_FULL;
        end else begin
          we_a    = cmd_i.commit;
          wr_a_d  = (wr_a_q == PTR_LAST) ? '0 : wr_a_q + 1'b1;
          cnt_a_d = cnt_a_q + 1'b1;
        end
      end
      CMD_PUSH_B: begin
        if (cnt_b_q == CNT_FULL) begin
          out_status_d = ST_FULL;
        end else begin
          we_b    = cmd_i.commit;
          wr_b_d  = (wr_b_q == PTR_LAST) ? '0 : wr_b_q + 1'b1;
          cnt_b_d = cnt_b_q + 1'b1;
        end
      end
      CMD_POP: begin
        if (!have_a && !have_b) begin
          out_status_d = ST_EMPTY;
        end else if (take_a) begin
          out_key_d = head_a_q[REC_W-1:TAG_W];
          out_tag_d = head_a_q[TAG_W-1:0];
          rd_a_d    = (rd_a_q == PTR_LAST) ? '0 : rd_a_q + 1'b1;
          cnt_a_d   = cnt_a_q - 1'b1;
        end else begin
          out_key_d = head_b_q[REC_W-1:TAG_W];
          out_tag_d = head_b_q[TAG_W-1:0];
          out_run_d = 1'b1;
          rd_b_d    = (rd_b_q == PTR_LAST) ? '0 : rd_b_q + 1'b1;
          cnt_b_d   = cnt_b_q - 1'b1;
        end
      end
      default: begin
        // Unused command: no state change, plain ok result
      end
    endcase
  end

  // Advance pointers and counts on commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_a_q  <= '0;
      wr_a_q  <= '0;
      cnt_a_q <= '0;
      rd_b_q  <= '0;
      wr_b_q  <= '0;
      cnt_b_q <= '0;
    end else if (cmd_i.commit) begin
      rd_a_q  <= rd_a_d;
      wr_a_q  <= wr_a_d;
      cnt_a_q <= cnt_a_d;
      rd_b_q  <= rd_b_d;
      wr_b_q  <= wr_b_d;
      cnt_b_q <= cnt_b_d;
    end
  end

  // Hold the result until the master side takes it
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_key_q    <= out_key_d;
      out_tag_q    <= out_tag_d;
      out_run_q    <= out_run_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_key_o      = out_key_q;
  assign out_tag_o      = out_tag_q;
  assign out_from_run_o = out_run_q;
  assign out_status_o   = out_status_q;

endmodule

`default_nettype wire

FILE: hdl/tdmq_chk.sv
`default_nettype none
`include "assert_macros.svh"

module tdmq_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [63:0] m_axis_tdata_o,
  input wire logic [2:0]  m_axis_tuser_o
);
  import tdmq_pkg::*;

  // A stalled result stays offered
  `TDMQ_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)

  // The block works on one transaction at a time
  `TDMQ_ASSERT(a_one_in_flight, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)

  // Refused pushes and empty pops carry no record
  `TDMQ_ASSERT(a_err_no_data,
               m_axis_tvalid_o && (m_axis_tuser_o[2:1] != ST_OK) |-> m_axis_tdata_o == 64'd0)

  // A pop from run B is always a successful one
  `TDMQ_ASSERT(a_run_b_ok, m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tuser_o[2:1] == ST_OK)

  // Nothing is offered once reset has been seen low at a clock edge
  `TDMQ_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid_o)

endmodule

bind two_way_descending_merge_queue tdmq_chk u_tdmq_chk (.*);

`default_nettype wire

FILE: sim/testbench.sv
`default_nettype none

module testbench;
  import tdmq_pkg::*;

  localparam int unsigned RUN_DEPTH = 512;
  localparam int unsigned PTR_W = $clog2(RUN_DEPTH);
  localparam int unsigned CNT_W = $clog2(RUN_DEPTH + 1);
  // Unused command code: no state change, plain ok result
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned KEY_STEP = 32'h0010_0000;

  typedef struct packed {
    bit [31:0] key;
    bit [31:0] tag;
    bit        from_run;
    bit [1:0]  status;
  } merge_result_t;

  // Track both runs and the results still owed by the block
  class merge_scoreboard;
    bit [63:0]      store [2][RUN_DEPTH];  // {key, tag}
    bit [PTR_W-1:0] rd_ptr [2];
    bit [PTR_W-1:0] wr_ptr [2];
    bit [CNT_W-1:0] fill [2];
    merge_result_t  awaited [$];
    int unsigned    mismatches;

    function bit [PTR_W-1:0] advance(bit [PTR_W-1:0] p);
      return (p == PTR_W'(RUN_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function int held(int side);
      return int'(fill[side]);
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    // Apply one accepted transaction to the runs and queue its result
    function void note_input(logic [1:0] cmd, logic [31:0] key, logic [31:0] tag);
      merge_result_t res;
      int            side;
      bit [63:0]     rec;
      res = '0;
      side = 0;
      case (cmd)
        CMD_PUSH_A, CMD_PUSH_B: begin
          side = (cmd == CMD_PUSH_B) ? 1 : 0;
          if (fill[side] == CNT_W'(RUN_DEPTH)) begin
            res.status = ST_FULL;
          end else begin
            store[side][wr_ptr[side]] = {key, tag};
            wr_ptr[side] = advance(wr_ptr[side]);
            fill[side] = fill[side] + 1'b1;
          end
        end
        CMD_POP: begin
          if (fill[0] == 0 && fill[1] == 0) begin
            res.status = ST_EMPTY;
          end else begin
            // Greater head key wins, ties go to run A
            if (fill[0] == 0) side = 1;
            else if (fill[1] == 0) side = 0;
            else side = (store[0][rd_ptr[0]][63:32] >= store[1][rd_ptr[1]][63:32]) ? 0 : 1;
            rec = store[side][rd_ptr[side]];
            rd_ptr[side] = advance(rd_ptr[side]);
            fill[side] = fill[side] - 1'b1;
            res.key = rec[63:32];
            res.tag = rec[31:0];
            res.from_run = side[0];
          end
        end
        default: ;  // unused code leaves the runs alone
      endcase
      awaited = {awaited, res};
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: mismatch on %0s: got %h, want %h", $time, what, got, want);
      mismatches++;
    endtask

    // Compare one result transaction with the oldest queued result
    task check_result(logic [63:0] data, logic [2:0] user);
      merge_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch("result with nothing outstanding", data, '0);
        return;
      end
      want = awaited.pop_front();
      if (data[31:0] !== want.key) report_mismatch("out_key", data[31:0], want.key);
      if (data[63:32] !== want.tag) report_mismatch("out_tag", data[63:32], want.tag);
      if (user[0] !== want.from_run) report_mismatch("from_run", user[0], want.from_run);
      if (user[2:1] !== want.status) report_mismatch("status", user[2:1], want.status);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = CMD_UNUSED;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  merge_scoreboard merge_sb;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  int unsigned     items_sent = 0;
  logic [31:0]     key_cursor = '0;

  two_way_descending_merge_queue #(.RUN_DEPTH(RUN_DEPTH)) u_top (.*);

  always #5 clk_i = ~clk_i;

  // Stall the result side at random
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check every result transaction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      merge_sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  // Offer one transaction and hold it until accepted; enter and leave at a falling edge
  task automatic send_item(logic [1:0] cmd, logic [31:0] key, logic [31:0] tag);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {tag, key};
    s_axis_tuser_i <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    merge_sb.note_input(cmd, key, tag);
    if (cmd != CMD_UNUSED) items_sent++;
    @(negedge clk_i);
  endtask

  // Hold off input until every queued result has arrived
  task automatic drain_wait();
    s_axis_tvalid_i <= 1'b0;
    @(negedge clk_i);
    while (merge_sb.outstanding() != 0) @(negedge clk_i);
  endtask

  // Step the key down, sometimes repeating it to make ties
  function automatic logic [31:0] next_desc_key(int unsigned max_step);
    if ($urandom_range(0, 3) != 0) begin
      key_cursor = key_cursor - $urandom_range(0, (key_cursor > max_step) ? max_step
                                                                         : key_cursor);
    end
    return key_cursor;
  endfunction

  // Split one descending sequence over both runs with occasional pops, then pop until both are empty
  task automatic merge_episode();
    int unsigned n;
    n = $urandom_range(1, 24);
    key_cursor = $urandom_range(0, 32'h7f80_0000);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) send_item(CMD_POP, $urandom, $urandom);
      send_item($urandom_range(0, 1) ? CMD_PUSH_B : CMD_PUSH_A, next_desc_key(KEY_STEP),
                $urandom);
    end
    while (merge_sb.held(0) + merge_sb.held(1) != 0) send_item(CMD_POP, $urandom, $urandom);
    if ($urandom_range(0, 2) == 0) send_item(CMD_POP, $urandom, $urandom);
  endtask

  // Fully random commands and keys
  task automatic noise_burst();
    repeat ($urandom_range(1, 6)) send_item(2'($urandom_range(0, 3)), $urandom, $urandom);
  endtask

  task automatic random_phase(int unsigned target);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(0, 99) < 75) merge_episode();
      else noise_burst();
    end
  endtask

  // Fill run A past full through the write pointer wrap, churn at full, pop part of it
  task automatic fill_and_drain();
    key_cursor = 32'h7f00_0000;
    while (merge_sb.held(0) != RUN_DEPTH) begin
      send_item(CMD_PUSH_A, next_desc_key(KEY_STEP / 2), $urandom);
    end
    repeat (2) send_item(CMD_PUSH_A, $urandom, $urandom);
    repeat (8) send_item(2'($urandom_range(0, 2)), $urandom, $urandom);
    repeat (24) send_item(CMD_POP, $urandom, $urandom);
  endtask

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    merge_sb = new();
    send_idle_pct = 37;
    recv_idle_pct = 81;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty pop, ignored code, field extremes, ties, lone runs, sign bit
    send_item(CMD_POP, 32'hffff_ffff, 32'hffff_ffff);
    send_item(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
    send_item(CMD_PUSH_A, 32'hffff_ffff, 32'hffff_ffff);
    send_item(CMD_PUSH_B, 32'h0000_0000, 32'h0000_0000);
    send_item(CMD_PUSH_A, 32'h7f80_0000, 32'h0000_0001);
    send_item(CMD_PUSH_B, 32'h7f80_0000, 32'h0000_0002);
    repeat (5) send_item(CMD_POP, 32'h0, 32'h0);
    send_item(CMD_PUSH_B, 32'h3f80_0000, 32'h0000_0010);
    send_item(CMD_PUSH_B, 32'h3f80_0000, 32'h0000_0011);
    send_item(CMD_PUSH_A, 32'h3f80_0000, 32'h0000_0012);
    repeat (3) send_item(CMD_POP, 32'h0, 32'h0);
    send_item(CMD_PUSH_A, 32'h8000_0000, 32'h5555_5555);
    send_item(CMD_PUSH_B, 32'h7fff_ffff, 32'haaaa_aaaa);
    repeat (2) send_item(CMD_POP, 32'h0, 32'h0);
    send_item(CMD_UNUSED, 32'h0, 32'h0);
    send_item(CMD_POP, 32'h0, 32'h0);

    random_phase(30);
    drain_wait();

    send_idle_pct = 81;
    recv_idle_pct = 37;
    random_phase(30);
    drain_wait();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(30);
    fill_and_drain();

    drain_wait();
    repeat (8) @(posedge clk_i);
    if (merge_sb.mismatches == 0 && merge_sb.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
